>>> design/pwc_pkg.sv
// pwc_pkg: shared constants, types and tag helpers for the page walk cache lookup
// no dependencies; used by every other file of the block but pwc_ram
package pwc_pkg;

    // geometry of the page table and the caches
    localparam int LEVEL_BITS = 9;
    localparam int LEVELS     = 4;
    localparam int NUM_CACHES = 3;
    localparam int SETS       = 16;
    localparam int WAYS       = 4;

    // payload widths
    localparam int VPN_W   = 36;
    localparam int NOW_W   = 32;
    localparam int START_W = 2;
    localparam int MASK_W  = 3;

    // storage widths
    localparam int TAG_W   = 27;
    localparam int STAMP_W = 32;
    localparam int ENTRY_W = TAG_W + STAMP_W;
    localparam int ROW_W   = WAYS * ENTRY_W;
    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef enum logic
    {
        ST_IDLE,
        ST_LOOKUP
    } pwc_state_t;

    // outcome of one cache probe
    typedef struct packed
    {
        logic             hit;
        logic [WAY_W-1:0] way;
    } pwc_sel_t;

    // prefix of the top (NUM_CACHES-c) level indices, used as the full tag
    function automatic logic [TAG_W-1:0] tag_of(input int c, input logic [VPN_W-1:0] vpn);
        int                kept;
        int                shift;
        logic [VPN_W-1:0]  shifted;
        logic [TAG_W-1:0]  keep_mask;
        kept  = NUM_CACHES - c;
        shift = (LEVELS - kept) * LEVEL_BITS;
        if (shift < 0)
        begin
            shift = 0;
        end
        shifted = vpn >> shift;
        for (int b = 0; b < TAG_W; b++)
        begin
            keep_mask[b] = (b < kept * LEVEL_BITS);
        end
        return TAG_W'(shifted) & keep_mask;
    endfunction

    // set index from the low tag bits
    function automatic logic [SET_W-1:0] set_of(input logic [TAG_W-1:0] tag);
        return SET_W'(tag & TAG_W'(SETS - 1));
    endfunction

endpackage

>>> design/pwc_in_if.sv
// pwc_in_if: lookup request channel, page number and timestamp
// depends on pwc_pkg for the field widths
interface pwc_in_if;
    logic                            valid;
    logic                            ready;
    logic [pwc_pkg::VPN_W-1:0]       page_number;
    logic [pwc_pkg::NOW_W-1:0]       now;

    modport source (output valid, output page_number, output now, input ready);
    modport sink   (input valid, input page_number, input now, output ready);
endinterface

>>> design/pwc_out_if.sv
// pwc_out_if: lookup result channel, start level and hit mask
// depends on pwc_pkg for the field widths
interface pwc_out_if;
    logic                            valid;
    logic                            ready;
    logic [pwc_pkg::START_W-1:0]     start_level;
    logic [pwc_pkg::MASK_W-1:0]      hit_mask;

    modport source (output valid, output start_level, output hit_mask, input ready);
    modport sink   (input valid, input start_level, input hit_mask, output ready);
endinterface

>>> design/page_walk_cache_lookup.sv
// page_walk_cache_lookup: a new request is taken only once the last lookup has finished;
// the set read is registered in the ram of each cache, and the compare, victim choice and
// write back follow in the lookup state. the result is registered at the end of the lookup
// state; a request is taken while a finished result still waits, and a lookup holds in
// place while the result slot is full.
// rst_n clears all valid bits and the control state at once; no clearing pass.
module page_walk_cache_lookup (
    input  logic      clk,
    input  logic      rst_n,
    pwc_in_if.sink    req,
    pwc_out_if.source rsp
);

    localparam int NC = pwc_pkg::NUM_CACHES;

    pwc_pkg::pwc_state_t state_reg;
    pwc_pkg::pwc_state_t state_next;

    logic [pwc_pkg::TAG_W-1:0]     tag_reg  [NC];
    logic [pwc_pkg::STAMP_W-1:0]   now_reg;
    logic [pwc_pkg::ROW_W-1:0]     row_rd   [NC];
    logic [pwc_pkg::ROW_W-1:0]     row_wr   [NC];
    logic [pwc_pkg::SET_W-1:0]     rd_set   [NC];
    logic [pwc_pkg::SET_W-1:0]     cur_set  [NC];
    pwc_pkg::pwc_sel_t             sel      [NC];
    logic [pwc_pkg::SETS-1:0][pwc_pkg::WAYS-1:0] valid_reg [NC];

    logic                          rsp_valid_reg;
    logic [pwc_pkg::START_W-1:0]   start_reg;
    logic [pwc_pkg::START_W-1:0]   start_next;
    logic [pwc_pkg::MASK_W-1:0]    mask_reg;
    logic [pwc_pkg::MASK_W-1:0]    mask_next;
    logic [NC-1:0]                 hits;

    logic accept;
    logic slot_free;
    logic finish;

    assign req.ready = (state_reg == pwc_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign finish    = (state_reg == pwc_pkg::ST_LOOKUP) && slot_free;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pwc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state: read set, then update and report
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pwc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = pwc_pkg::ST_LOOKUP;
                end
            end
            pwc_pkg::ST_LOOKUP:
            begin
                if (slot_free)
                begin
                    state_next = pwc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pwc_pkg::ST_IDLE;
            end
        endcase
    end

    // capture request payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= req.now;
        end
    end

    // one ram, one way selector and one array of valid bits per cache
    for (genvar c = 0; c < NC; c++)
    begin : g_cache
        assign rd_set[c]  = pwc_pkg::set_of(pwc_pkg::tag_of(c, req.page_number));
        assign cur_set[c] = pwc_pkg::set_of(tag_reg[c]);

        always_ff @(posedge clk)
        begin
            if (accept)
            begin
                tag_reg[c] <= pwc_pkg::tag_of(c, req.page_number);
            end
        end

        pwc_ram #(
            .WIDTH (pwc_pkg::ROW_W),
            .DEPTH (pwc_pkg::SETS)
        ) u_ram (
            .clk   (clk),
            .we    (finish),
            .waddr (cur_set[c]),
            .wdata (row_wr[c]),
            .re    (accept),
            .raddr (rd_set[c]),
            .rdata (row_rd[c])
        );

        pwc_way_sel u_sel (
            .tag   (tag_reg[c]),
            .row   (row_rd[c]),
            .valid (valid_reg[c][cur_set[c]]),
            .sel   (sel[c])
        );

        // chosen way gets the tag and the fresh stamp
        always_comb
        begin
            row_wr[c] = row_rd[c];
            row_wr[c][sel[c].way*pwc_pkg::ENTRY_W +: pwc_pkg::ENTRY_W] =
                {tag_reg[c], now_reg};
        end

        // valid bits, set on every fill
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[c] <= '0;
            end
            else if (finish)
            begin
                valid_reg[c][cur_set[c]][sel[c].way] <= 1'b1;
            end
        end

        assign hits[c] = sel[c].hit;
    end

    // smallest cache index that hit, or LEVELS-1 on no hit; mask of every hit
    always_comb
    begin
        start_next = pwc_pkg::START_W'(pwc_pkg::LEVELS - 1);
        for (int i = NC - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                start_next = pwc_pkg::START_W'(i);
            end
        end
        mask_next = pwc_pkg::MASK_W'(hits);
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            start_reg <= start_next;
            mask_reg  <= mask_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.start_level = start_reg;
    assign rsp.hit_mask    = mask_reg;

    // a request transfer always moves on to the set compare
    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == pwc_pkg::ST_LOOKUP)
        else $error("request transfer not followed by lookup");

    // a new result only comes from a finished lookup
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == pwc_pkg::ST_LOOKUP))
        else $error("result raised without a lookup");

    // a stalled lookup keeps its set data
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pwc_pkg::ST_LOOKUP && !slot_free) |=>
        (state_reg == pwc_pkg::ST_LOOKUP && $stable(row_rd[0])))
        else $error("set data lost during stall");

endmodule

>>> design/pwc_ram.sv
// pwc_ram: generic single write port, single read port ram with registered read
// no dependencies
module pwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/pwc_way_sel.sv
// pwc_way_sel: tag compare and replacement choice over the ways of one set
// depends on pwc_pkg for widths and the pwc_sel_t result type
module pwc_way_sel (
    input  logic [pwc_pkg::TAG_W-1:0]  tag,
    input  logic [pwc_pkg::ROW_W-1:0]  row,
    input  logic [pwc_pkg::WAYS-1:0]   valid,
    output pwc_pkg::pwc_sel_t          sel
);

    logic [pwc_pkg::TAG_W-1:0]   way_tag   [pwc_pkg::WAYS];
    logic [pwc_pkg::STAMP_W-1:0] way_stamp [pwc_pkg::WAYS];

    // split the row into entries, tag above stamp
    always_comb
    begin
        for (int w = 0; w < pwc_pkg::WAYS; w++)
        begin
            {way_tag[w], way_stamp[w]} = row[w*pwc_pkg::ENTRY_W +: pwc_pkg::ENTRY_W];
        end
    end

    // lowest matching way wins, else first free way, else oldest stamp
    always_comb
    begin
        logic                        found;
        logic                        free_found;
        logic [pwc_pkg::WAY_W-1:0]   hit_way;
        logic [pwc_pkg::WAY_W-1:0]   free_way;
        logic [pwc_pkg::WAY_W-1:0]   old_way;
        logic [pwc_pkg::STAMP_W-1:0] old_stamp;
        found      = 1'b0;
        free_found = 1'b0;
        hit_way    = '0;
        free_way   = '0;
        old_way    = '0;
        old_stamp  = way_stamp[0];
        for (int w = 0; w < pwc_pkg::WAYS; w++)
        begin
            if (!found && valid[w] && way_tag[w] == tag)
            begin
                found   = 1'b1;
                hit_way = pwc_pkg::WAY_W'(w);
            end
            if (!free_found && !valid[w])
            begin
                free_found = 1'b1;
                free_way   = pwc_pkg::WAY_W'(w);
            end
            if (way_stamp[w] < old_stamp)
            begin
                old_stamp = way_stamp[w];
                old_way   = pwc_pkg::WAY_W'(w);
            end
        end
        sel.hit = found;
        if (found)
        begin
            sel.way = hit_way;
        end
        else if (free_found)
        begin
            sel.way = free_way;
        end
        else
        begin
            sel.way = old_way;
        end
    end

endmodule

>>> tb/sv/page_walk_cache_lookup_test.sv
// page_walk_cache_lookup_test: self-checking bench for the page walk cache lookup
// predicts start level and hit mask per lookup from its own copy of the cache state
// depends on pwc_pkg, pwc_in_if, pwc_out_if and page_walk_cache_lookup
module page_walk_cache_lookup_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 20;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int POOL_SIZE    = 12;

    typedef struct packed
    {
        logic [pwc_pkg::START_W-1:0] start_level;
        logic [pwc_pkg::MASK_W-1:0]  hit_mask;
    } lookup_result_t;

    logic clk;
    logic rst_n;

    pwc_in_if  req_if ();
    pwc_out_if rsp_if ();

    page_walk_cache_lookup DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    // shadow copy of every cache entry
    logic line_valid [pwc_pkg::NUM_CACHES][pwc_pkg::SETS][pwc_pkg::WAYS];
    logic [pwc_pkg::TAG_W-1:0]
          line_tag   [pwc_pkg::NUM_CACHES][pwc_pkg::SETS][pwc_pkg::WAYS];
    logic [pwc_pkg::STAMP_W-1:0]
          line_stamp [pwc_pkg::NUM_CACHES][pwc_pkg::SETS][pwc_pkg::WAYS];

    lookup_result_t pending_results [$];

    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned error_count;
    int unsigned cycle_count;
    logic        hold_req;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // probe every cache, refresh on hit, fill on miss
    function automatic lookup_result_t predict_lookup(
        input logic [pwc_pkg::VPN_W-1:0] vpn,
        input logic [pwc_pkg::NOW_W-1:0] stamp);
        lookup_result_t            res;
        int                        kept;
        int                        shift;
        int                        set_idx;
        int                        hit_way;
        int                        victim;
        logic [63:0]               prefix;
        logic [pwc_pkg::TAG_W-1:0] tag;
        res.start_level = pwc_pkg::START_W'(pwc_pkg::LEVELS - 1);
        res.hit_mask    = '0;
        for (int c = pwc_pkg::NUM_CACHES - 1; c >= 0; c--)
        begin
            kept  = pwc_pkg::NUM_CACHES - c;
            shift = (pwc_pkg::LEVELS - kept) * pwc_pkg::LEVEL_BITS;
            if (shift < 0)
            begin
                shift = 0;
            end
            prefix = 64'(vpn) >> shift;
            if (kept * pwc_pkg::LEVEL_BITS < 64)
            begin
                prefix &= (64'd1 << (kept * pwc_pkg::LEVEL_BITS)) - 64'd1;
            end
            tag     = pwc_pkg::TAG_W'(prefix);
            set_idx = int'(prefix & 64'(pwc_pkg::SETS - 1));
            hit_way = -1;
            for (int w = 0; w < pwc_pkg::WAYS; w++)
            begin
                if (hit_way < 0 && line_valid[c][set_idx][w] && line_tag[c][set_idx][w] == tag)
                begin
                    hit_way = w;
                end
            end
            if (hit_way >= 0)
            begin
                line_stamp[c][set_idx][hit_way] = stamp;
                res.start_level = pwc_pkg::START_W'(c);
                res.hit_mask[c] = 1'b1;
            end
            else
            begin
                // first free way, else oldest stamp with lowest way on a tie
                victim = -1;
                for (int w = 0; w < pwc_pkg::WAYS; w++)
                begin
                    if (victim < 0 && !line_valid[c][set_idx][w])
                    begin
                        victim = w;
                    end
                end
                if (victim < 0)
                begin
                    victim = 0;
                    for (int w = 1; w < pwc_pkg::WAYS; w++)
                    begin
                        if (line_stamp[c][set_idx][w] < line_stamp[c][set_idx][victim])
                        begin
                            victim = w;
                        end
                    end
                end
                line_valid[c][set_idx][victim] = 1'b1;
                line_tag[c][set_idx][victim]   = tag;
                line_stamp[c][set_idx][victim] = stamp;
            end
        end
        return res;
    endfunction

    // predict on each request transfer, compare on each result transfer
    always @(posedge clk)
    begin : monitor
        lookup_result_t want;
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
            begin
                pending_results.push_back(predict_lookup(req_if.page_number, req_if.now));
            end
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with nothing pending: start_level=%0d hit_mask=%0b",
                           rsp_if.start_level, rsp_if.hit_mask);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_if.start_level !== want.start_level)
                    begin
                        $error("start_level expected %0d actual %0d",
                               want.start_level, rsp_if.start_level);
                        error_count++;
                    end
                    if (rsp_if.hit_mask !== want.hit_mask)
                    begin
                        $error("hit_mask expected %0b actual %0b",
                               want.hit_mask, rsp_if.hit_mask);
                        error_count++;
                    end
                end
            end
        end
    end

    // result side: random stalls, or a long hold-off on request
    initial
    begin
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // offer one lookup, with random idle cycles ahead of it, until it transfers
    task automatic send_lookup(input logic [pwc_pkg::VPN_W-1:0] vpn,
                               input logic [pwc_pkg::NOW_W-1:0] stamp);
        while ($urandom_range(99) < idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.page_number <= vpn;
        req_if.now         <= stamp;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
    endtask

    // drop valid and wait for the clock first, so the last request transfer is already queued
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // all-zero and all-one pages and stamps, partial prefix matches
    task automatic test_corner_pages();
        idle_pct  = 0;
        stall_pct = 0;
        send_lookup(36'h0, 32'h0);
        send_lookup(36'h0, 32'hFFFF_FFFF);
        send_lookup(36'hF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_lookup(36'hF_FFFF_FFFF, 32'h0);
        send_lookup(36'hF_FFFF_FE00, 32'h1);
        send_lookup(36'hF_FFFC_0000, 32'h2);
        send_lookup(36'hF_F800_0000, 32'h3);
        send_lookup(36'hA_AAAA_AAAA, 32'hAAAA_AAAA);
        send_lookup(36'h5_5555_5555, 32'h5555_5555);
        send_lookup(36'hA_AAAA_AAAA, 32'h5555_5555);
        wait_drained();
    endtask

    // fill one set past its ways: oldest stamp evicted, lowest way on a tie
    task automatic test_lru_replacement();
        logic [4:0]                order_a  [10] = '{0, 1, 2, 3, 4, 1, 0, 2, 5, 3};
        logic [pwc_pkg::NOW_W-1:0] stamps_a [10] =
            '{100, 50, 200, 50, 300, 60, 400, 500, 600, 700};
        idle_pct  = 0;
        stall_pct = 0;
        for (int k = 0; k < 10; k++)
        begin
            send_lookup({order_a[k], 4'h5, 27'($urandom)}, stamps_a[k]);
        end
        // equal stamps everywhere: way 0 goes first
        for (int k = 0; k < 6; k++)
        begin
            send_lookup({5'(k % 5), 4'h9, 27'($urandom)}, 32'd7);
        end
        wait_drained();
    endtask

    // result side held off while requests keep coming, so the block backs up
    task automatic test_full_stall();
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b1;
        for (int k = 0; k < 40; k++)
        begin
            send_lookup({9'($urandom_range(3)), 27'($urandom)}, pwc_pkg::NOW_W'(k));
        end
        wait_drained();
    endtask

    // lookups drawn from small prefix pools so that sets fill and evict
    task automatic test_mixed_traffic(input int unsigned count, input int unsigned idle,
                                      input int unsigned stall);
        logic [8:0]                top_pool [POOL_SIZE];
        logic [8:0]                mid_pool [POOL_SIZE];
        logic [8:0]                low_pool [POOL_SIZE];
        logic [3:0]                set_a;
        logic [3:0]                set_b;
        logic [pwc_pkg::NOW_W-1:0] clock_now;
        logic [pwc_pkg::VPN_W-1:0] vpn;
        logic [pwc_pkg::NOW_W-1:0] stamp;
        idle_pct  = idle;
        stall_pct = stall;
        set_a     = 4'($urandom);
        set_b     = 4'($urandom);
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            top_pool[k] = {5'($urandom), k[0] ? set_a : set_b};
            mid_pool[k] = {5'($urandom), k[0] ? set_b : set_a};
            low_pool[k] = {5'($urandom), k[0] ? ~set_a : set_a};
        end
        clock_now = $urandom;
        for (int unsigned n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 8)
            begin
                vpn = {4'($urandom), 32'($urandom)};
            end
            else
            begin
                vpn = {top_pool[$urandom_range(POOL_SIZE - 1)],
                       mid_pool[$urandom_range(POOL_SIZE - 1)],
                       low_pool[$urandom_range(POOL_SIZE - 1)],
                       9'($urandom)};
            end
            // mostly a slowly rising clock with repeats, now and then a wild stamp
            if ($urandom_range(99) < 5)
            begin
                stamp = $urandom;
            end
            else
            begin
                clock_now = clock_now + pwc_pkg::NOW_W'($urandom_range(2));
                stamp     = clock_now;
            end
            send_lookup(vpn, stamp);
        end
        wait_drained();
    endtask

    // reset, then the tests in turn
    initial
    begin
        rst_n              <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.page_number <= '0;
        req_if.now         <= '0;
        idle_pct    = 0;
        stall_pct   = 0;
        error_count = 0;
        cycle_count = 0;
        hold_req    = 1'b0;
        for (int c = 0; c < pwc_pkg::NUM_CACHES; c++)
        begin
            for (int s = 0; s < pwc_pkg::SETS; s++)
            begin
                for (int w = 0; w < pwc_pkg::WAYS; w++)
                begin
                    line_valid[c][s][w] = 1'b0;
                end
            end
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_pages();
        test_lru_replacement();
        test_full_stall();
        test_mixed_traffic(450, 0, 0);
        test_mixed_traffic(450, 81, 0);
        test_mixed_traffic(450, 0, 81);
        test_mixed_traffic(450, 23, 23);

        repeat (DRAIN_CYCLES) @(posedge clk);
        // every predicted result must have come out
        if (pending_results.size() != 0)
        begin
            $error("pending results expected 0 actual %0d", pending_results.size());
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
